>>> design/assert_macros.svh
// Assertion macros used by the checker file, ctm_checker.sv.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctm assertion failed");

// Next-cycle implication, disabled during reset.
`define CTM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctm assertion failed");

`endif

>>> design/ctm_pkg.sv
// Types, codes and time decoders for the cron time match table.
// No dependencies; used by every module of the block.
`default_nettype none

package ctm_pkg;

    localparam int NUM_JOBS_DEF = 32;
    localparam int JOB_IDX_W    = 5;
    localparam int VALUE_W      = 60;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] FS_SEC     = 3'd0;
    localparam logic [2:0] FS_MIN     = 3'd1;
    localparam logic [2:0] FS_HOUR    = 3'd2;
    localparam logic [2:0] FS_DAY     = 3'd3;
    localparam logic [2:0] FS_MONTH   = 3'd4;
    localparam logic [2:0] FS_WEEKDAY = 3'd5;
    localparam logic [2:0] FS_FLAGS   = 3'd6;

    localparam int FLAG_PRESENT = 0;
    localparam int FLAG_BOOT    = 1;
    localparam int FLAG_DAY_ANY = 2;
    localparam int FLAG_DOW_ANY = 3;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [JOB_IDX_W-1:0] job_index;
        logic [2:0]           field_select;
        logic [VALUE_W-1:0]   field_value;
        logic [5:0]           second;
        logic [5:0]           minute;
        logic [4:0]           hour;
        logic [4:0]           day_of_month;
        logic [3:0]           month_number;
        logic [2:0]           day_of_week;
    } ctm_in_t;

    typedef struct packed {
        logic [JOB_IDX_W-1:0] due_job;
        logic                 is_last;
    } ctm_out_t;

    // Decoded tick time, broadcast to every cell.
    typedef struct packed {
        logic [59:0] sec_oh;
        logic [59:0] min_oh;
        logic [23:0] hour_oh;
        logic [30:0] day_oh;
        logic [11:0] mon_oh;
        logic [7:0]  dow_oh;
    } ctm_tick_t;

    // Table write/clear command, broadcast to every cell.
    typedef struct packed {
        logic                 en;
        logic                 clr;
        logic [JOB_IDX_W-1:0] idx;
        logic [2:0]           sel;
        logic [VALUE_W-1:0]   value;
    } ctm_wr_t;

    function automatic logic [59:0] dec60(input logic [5:0] v);
        logic [59:0] d;
        d = '0;
        if (v < 6'd60)
            d[v] = 1'b1;
        return d;
    endfunction

    function automatic logic [23:0] dec24(input logic [4:0] v);
        logic [23:0] d;
        d = '0;
        if (v < 5'd24)
            d[v] = 1'b1;
        return d;
    endfunction

    // One-based day: day 1 is bit 0, day zero hits nothing.
    function automatic logic [30:0] dec_day(input logic [4:0] v);
        logic [30:0] d;
        d = '0;
        if (v != 5'd0)
            d[v - 5'd1] = 1'b1;
        return d;
    endfunction

    // One-based month, 1 to 12.
    function automatic logic [11:0] dec_mon(input logic [3:0] v);
        logic [11:0] d;
        d = '0;
        if ((v != 4'd0) && (v <= 4'd12))
            d[v - 4'd1] = 1'b1;
        return d;
    endfunction

    function automatic logic [7:0] dec8(input logic [2:0] v);
        logic [7:0] d;
        d = '0;
        d[v] = 1'b1;
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/ctm_job_cell.sv
// One job entry of the table with its scan token stage.
// Depends on ctm_pkg; instantiated in a chain by cron_time_match_table.
`default_nettype none

module ctm_job_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ctm_pkg::ctm_wr_t                  wr,
    input  wire ctm_pkg::ctm_tick_t                tick,
    input  wire logic                              advance,
    input  wire logic                              token_in,
    output logic                                   token_out,
    output logic                                   hit,
    output logic [ctm_pkg::JOB_IDX_W-1:0]          hit_idx
);

    localparam logic [6:0] ID_WIDE = CELL_ID[6:0];
    localparam logic [ctm_pkg::JOB_IDX_W-1:0] ID_SHORT = CELL_ID[ctm_pkg::JOB_IDX_W-1:0];

    logic [59:0] sec_mask_reg,  sec_mask_next;
    logic [59:0] min_mask_reg,  min_mask_next;
    logic [23:0] hour_mask_reg, hour_mask_next;
    logic [30:0] day_mask_reg,  day_mask_next;
    logic [11:0] mon_mask_reg,  mon_mask_next;
    logic [7:0]  dow_mask_reg,  dow_mask_next;
    logic [3:0]  flags_reg,     flags_next;
    logic        token_reg,     token_next;

    logic sel_me;
    logic present;
    logic boot;
    logic dm;
    logic wm;
    logic day_ok;
    logic due;

    assign sel_me  = wr.en && ({2'b00, wr.idx} == ID_WIDE);
    assign present = flags_reg[ctm_pkg::FLAG_PRESENT];
    assign boot    = flags_reg[ctm_pkg::FLAG_BOOT];

    assign dm = |(day_mask_reg & tick.day_oh);
    assign wm = |(dow_mask_reg & tick.dow_oh);

    always_comb
    begin
        if (flags_reg[ctm_pkg::FLAG_DAY_ANY] || flags_reg[ctm_pkg::FLAG_DOW_ANY])
            day_ok = dm && wm;
        else
            day_ok = dm || wm;
    end

    assign due = present && (boot ||
                 ((|(sec_mask_reg & tick.sec_oh)) &&
                  (|(min_mask_reg & tick.min_oh)) &&
                  (|(hour_mask_reg & tick.hour_oh)) &&
                  (|(mon_mask_reg & tick.mon_oh)) && day_ok));

    assign hit       = token_reg && due;
    assign hit_idx   = hit ? ID_SHORT : '0;
    assign token_out = token_reg;

    always_comb
    begin
        sec_mask_next  = sec_mask_reg;
        min_mask_next  = min_mask_reg;
        hour_mask_next = hour_mask_reg;
        day_mask_next  = day_mask_reg;
        mon_mask_next  = mon_mask_reg;
        dow_mask_next  = dow_mask_reg;
        flags_next     = flags_reg;
        token_next     = advance ? token_in : token_reg;
        if (wr.clr)
        begin
            sec_mask_next  = '0;
            min_mask_next  = '0;
            hour_mask_next = '0;
            day_mask_next  = '0;
            mon_mask_next  = '0;
            dow_mask_next  = '0;
            flags_next     = '0;
        end
        else if (sel_me)
        begin
            unique case (wr.sel)
                ctm_pkg::FS_SEC:     sec_mask_next  = wr.value[59:0];
                ctm_pkg::FS_MIN:     min_mask_next  = wr.value[59:0];
                ctm_pkg::FS_HOUR:    hour_mask_next = wr.value[23:0];
                ctm_pkg::FS_DAY:     day_mask_next  = wr.value[30:0];
                ctm_pkg::FS_MONTH:   mon_mask_next  = wr.value[11:0];
                ctm_pkg::FS_WEEKDAY: dow_mask_next  = wr.value[7:0];
                ctm_pkg::FS_FLAGS:   flags_next     = wr.value[3:0];
                default:             ;
            endcase
        end
        else if (advance && token_reg && present && boot)
        begin
            // boot entry fires once
            flags_next[ctm_pkg::FLAG_BOOT] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_mask_reg  <= '0;
            min_mask_reg  <= '0;
            hour_mask_reg <= '0;
            day_mask_reg  <= '0;
            mon_mask_reg  <= '0;
            dow_mask_reg  <= '0;
            flags_reg     <= '0;
            token_reg     <= 1'b0;
        end
        else
        begin
            sec_mask_reg  <= sec_mask_next;
            min_mask_reg  <= min_mask_next;
            hour_mask_reg <= hour_mask_next;
            day_mask_reg  <= day_mask_next;
            mon_mask_reg  <= mon_mask_next;
            dow_mask_reg  <= dow_mask_next;
            flags_reg     <= flags_next;
            token_reg     <= token_next;
        end
    end

endmodule

`default_nettype wire

>>> design/cron_time_match_table.sv
// Top level of the cron time match table: cell chain, scan control, output word.
// Depends on ctm_pkg and ctm_job_cell.
//
//   port group        | dir | handshake            | word
//   in_valid/in_data  | in  | in_valid & in_ready  | ctm_pkg::ctm_in_t
//   out_valid/out_data| out | out_valid & out_ready| ctm_pkg::ctm_out_t
//
// Field write, table clear and unused opcodes do not leave the idle state.
// A tick walks a token down the chain, one job per cycle, pausing while the output
// is stalled and a due job waits to leave.
// The last due job of a tick is held one stage and leaves with is_last set.
// Reset empties the table at once; no clearing pass.
`default_nettype none

module cron_time_match_table #(
    parameter int NUM_JOBS = ctm_pkg::NUM_JOBS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ctm_pkg::ctm_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ctm_pkg::ctm_out_t      out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                         state_reg,     state_next;
    ctm_pkg::ctm_tick_t                 tick_reg,      tick_next;
    logic                               held_vld_reg,  held_vld_next;
    logic [ctm_pkg::JOB_IDX_W-1:0]      held_idx_reg,  held_idx_next;
    logic                               out_vld_reg,   out_vld_next;
    ctm_pkg::ctm_out_t                  out_reg,       out_next;

    ctm_pkg::ctm_wr_t                   wr;
    logic                               accept;
    logic                               start;
    logic                               advance;
    logic                               step_ok;
    logic                               slot_free;
    logic                               any_hit;
    logic [ctm_pkg::JOB_IDX_W-1:0]      hit_idx;
    logic [NUM_JOBS-1:0]                tok;
    logic [NUM_JOBS-1:0]                hits;
    logic [ctm_pkg::JOB_IDX_W-1:0]      cell_idx [NUM_JOBS];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign start     = accept && (in_data.opcode == ctm_pkg::OP_TICK);
    assign slot_free = !out_vld_reg || out_ready;
    assign any_hit   = |hits;

    always_comb
    begin
        hit_idx = '0;
        for (int j = 0; j < NUM_JOBS; j++)
            hit_idx = hit_idx | cell_idx[j];
    end

    assign step_ok = (state_reg == ST_SCAN) && !(any_hit && held_vld_reg && !slot_free);
    assign advance = start || step_ok;

    always_comb
    begin
        wr.en    = accept && (in_data.opcode == ctm_pkg::OP_WRITE);
        wr.clr   = accept && (in_data.opcode == ctm_pkg::OP_CLEAR);
        wr.idx   = in_data.job_index;
        wr.sel   = in_data.field_select;
        wr.value = in_data.field_value;
    end

    always_comb
    begin
        tick_next = tick_reg;
        if (start)
        begin
            tick_next.sec_oh  = ctm_pkg::dec60(in_data.second);
            tick_next.min_oh  = ctm_pkg::dec60(in_data.minute);
            tick_next.hour_oh = ctm_pkg::dec24(in_data.hour);
            tick_next.day_oh  = ctm_pkg::dec_day(in_data.day_of_month);
            tick_next.mon_oh  = ctm_pkg::dec_mon(in_data.month_number);
            tick_next.dow_oh  = ctm_pkg::dec8(in_data.day_of_week);
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_JOBS; g++)
        begin : g_cell
            logic tin;
            if (g == 0)
            begin : g_head
                assign tin = start;
            end
            else
            begin : g_link
                assign tin = tok[g-1];
            end
            ctm_job_cell #(
                .CELL_ID (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr        (wr),
                .tick      (tick_reg),
                .advance   (advance),
                .token_in  (tin),
                .token_out (tok[g]),
                .hit       (hits[g]),
                .hit_idx   (cell_idx[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        held_vld_next = held_vld_reg;
        held_idx_next = held_idx_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_next      = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (step_ok)
                begin
                    if (any_hit)
                    begin
                        if (held_vld_reg)
                        begin
                            out_vld_next     = 1'b1;
                            out_next.due_job = held_idx_reg;
                            out_next.is_last = 1'b0;
                        end
                        held_vld_next = 1'b1;
                        held_idx_next = hit_idx;
                    end
                    if (tok[NUM_JOBS-1])
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!held_vld_reg)
                    state_next = ST_IDLE;
                else if (slot_free)
                begin
                    out_vld_next     = 1'b1;
                    out_next.due_job = held_idx_reg;
                    out_next.is_last = 1'b1;
                    held_vld_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg     <= tick_next;
        held_idx_reg <= held_idx_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> design/ctm_checker.sv
// Port-level checker for cron_time_match_table, bound to the top level.
// Depends on ctm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ctm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire ctm_pkg::ctm_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ctm_pkg::ctm_out_t out_data
);

    logic tick_acc;
    logic other_acc;

    assign tick_acc  = in_valid && in_ready && (in_data.opcode == ctm_pkg::OP_TICK);
    assign other_acc = in_valid && in_ready && (in_data.opcode != ctm_pkg::OP_TICK);

    // a tick starts a scan, so input closes
    `CTM_ASSERT_NEXT(a_tick_busy, tick_acc, !in_ready)
    // writes, clears and unused opcodes leave input open
    `CTM_ASSERT_NEXT(a_cmd_quick, other_acc, in_ready)
    // words only appear during a scan
    `CTM_ASSERT_NOW(a_out_in_scan, $rose(out_valid), $past(!in_ready))
    `CTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind cron_time_match_table ctm_checker u_ctm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for cron_time_match_table: directed and random words, with every due
// job checked against a job table kept inside the bench.
// Depends on ctm_pkg and the cron_time_match_table RTL.

module tb;

    localparam int JOBS         = ctm_pkg::NUM_JOBS_DEF;
    localparam int LIMIT        = 200000;
    localparam int RANDOM_WORDS = 205;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] FS_UNUSED = 3'd7;

    class due_job_tracker;
        logic [59:0]        sec_m  [JOBS];
        logic [59:0]        min_m  [JOBS];
        logic [23:0]        hour_m [JOBS];
        logic [30:0]        day_m  [JOBS];
        logic [11:0]        mon_m  [JOBS];
        logic [7:0]         dow_m  [JOBS];
        logic [3:0]         flags  [JOBS];
        ctm_pkg::ctm_out_t  due_q[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            for (int j = 0; j < JOBS; j++)
            begin
                sec_m[j]  = '0;
                min_m[j]  = '0;
                hour_m[j] = '0;
                day_m[j]  = '0;
                mon_m[j]  = '0;
                dow_m[j]  = '0;
                flags[j]  = '0;
            end
        endfunction

        // bit n of a mask of the given width; anything outside never hits
        function bit hit(logic [63:0] mask, int n, int width);
            return (n >= 0 && n < width) ? mask[n] : 1'b0;
        endfunction

        function void write_field(ctm_pkg::ctm_in_t w);
            if (w.job_index >= JOBS)
                return;
            case (w.field_select)
                ctm_pkg::FS_SEC:     sec_m[w.job_index]  = w.field_value;
                ctm_pkg::FS_MIN:     min_m[w.job_index]  = w.field_value;
                ctm_pkg::FS_HOUR:    hour_m[w.job_index] = w.field_value[23:0];
                ctm_pkg::FS_DAY:     day_m[w.job_index]  = w.field_value[30:0];
                ctm_pkg::FS_MONTH:   mon_m[w.job_index]  = w.field_value[11:0];
                ctm_pkg::FS_WEEKDAY: dow_m[w.job_index]  = w.field_value[7:0];
                ctm_pkg::FS_FLAGS:   flags[w.job_index]  = w.field_value[3:0];
                default: ;
            endcase
        endfunction

        function void scan_tick(ctm_pkg::ctm_in_t w);
            int                 due_list[$];
            bit                 dm, wm, dayok, due;
            ctm_pkg::ctm_out_t  r;
            for (int j = 0; j < JOBS; j++)
            begin
                if (!flags[j][ctm_pkg::FLAG_PRESENT])
                    continue;
                if (flags[j][ctm_pkg::FLAG_BOOT])
                begin
                    flags[j][ctm_pkg::FLAG_BOOT] = 1'b0;
                    due = 1'b1;
                end
                else
                begin
                    dm = hit(64'(day_m[j]), int'(w.day_of_month) - 1, 31);
                    wm = hit(64'(dow_m[j]), int'(w.day_of_week), 8);
                    dayok = (flags[j][ctm_pkg::FLAG_DAY_ANY] ||
                             flags[j][ctm_pkg::FLAG_DOW_ANY]) ?
                            (dm && wm) : (dm || wm);
                    due = hit(64'(sec_m[j]), int'(w.second), 60) &&
                          hit(64'(min_m[j]), int'(w.minute), 60) &&
                          hit(64'(hour_m[j]), int'(w.hour), 24) &&
                          hit(64'(mon_m[j]), int'(w.month_number) - 1, 12) && dayok;
                end
                if (due)
                    due_list.push_back(j);
            end
            foreach (due_list[k])
            begin
                r.due_job = 5'(due_list[k]);
                r.is_last = (k == due_list.size() - 1);
                due_q.push_back(r);
            end
        endfunction

        function void note_word(ctm_pkg::ctm_in_t w);
            case (w.opcode)
                ctm_pkg::OP_TICK:  scan_tick(w);
                ctm_pkg::OP_WRITE: write_field(w);
                ctm_pkg::OP_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_word(ctm_pkg::ctm_out_t got);
            ctm_pkg::ctm_out_t want;
            if (due_q.size() == 0)
            begin
                flag_error($sformatf("unexpected word job %0d last %0b",
                                     got.due_job, got.is_last));
                return;
            end
            want = due_q.pop_front();
            if (got.due_job !== want.due_job || got.is_last !== want.is_last)
                flag_error($sformatf("job %0d last %0b, expected job %0d last %0b",
                                     got.due_job, got.is_last,
                                     want.due_job, want.is_last));
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ctm_pkg::ctm_in_t   in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ctm_pkg::ctm_out_t  out_data;
    bit                 steady = 1'b0;
    int                 words_sent = 0;
    int                 cycles = 0;

    due_job_tracker due_jobs = new();

    cron_time_match_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 12);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            due_jobs.check_word(out_data);

    function automatic ctm_pkg::ctm_in_t noise_word();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(ctm_pkg::ctm_in_t)-1:0];
    endfunction

    function automatic ctm_pkg::ctm_in_t write_word(input logic [4:0] idx,
                                                    input logic [2:0] sel,
                                                    input logic [59:0] val);
        ctm_pkg::ctm_in_t w;
        w = noise_word();
        w.opcode       = ctm_pkg::OP_WRITE;
        w.job_index    = idx;
        w.field_select = sel;
        w.field_value  = val;
        return w;
    endfunction

    function automatic ctm_pkg::ctm_in_t tick_word(input int s, input int m, input int h,
                                                   input int d, input int mo, input int dw);
        ctm_pkg::ctm_in_t w;
        w = noise_word();
        w.opcode       = ctm_pkg::OP_TICK;
        w.second       = 6'(s);
        w.minute       = 6'(m);
        w.hour         = 5'(h);
        w.day_of_month = 5'(d);
        w.month_number = 4'(mo);
        w.day_of_week  = 3'(dw);
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input ctm_pkg::ctm_in_t w);
        while (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due_jobs.note_word(w);
        if (w.opcode != OP_UNUSED &&
            !(w.opcode == ctm_pkg::OP_WRITE && w.field_select == FS_UNUSED))
            words_sent++;
        steady = (words_sent >= 110 && words_sent < 170);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_jobs.pending() != 0)
            @(negedge clk);
    endtask

    // dense masks so a fair share of ticks hit the job
    task automatic program_job(input logic [4:0] idx);
        logic [63:0] v;
        for (int s = int'(ctm_pkg::FS_SEC); s < int'(ctm_pkg::FS_FLAGS); s++)
        begin
            if ($urandom_range(9) == 0)
                v = '1;
            else
                v = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
            send_word(write_word(idx, 3'(s), v[59:0]));
        end
        v = {$urandom, $urandom};
        v[ctm_pkg::FLAG_PRESENT] = ($urandom_range(99) < 90);
        v[ctm_pkg::FLAG_BOOT]    = ($urandom_range(99) < 20);
        send_word(write_word(idx, ctm_pkg::FS_FLAGS, v[59:0]));
    endtask

    initial
    begin
        ctm_pkg::ctm_in_t w;
        int               pick;
        int               start;
        bit               drained;
        drained  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // empty table
        send_word(tick_word(0, 0, 0, 1, 1, 0));
        // job 0: every mask full, boot job
        for (int s = int'(ctm_pkg::FS_SEC); s < int'(ctm_pkg::FS_FLAGS); s++)
            send_word(write_word(5'd0, 3'(s), '1));
        send_word(write_word(5'd0, ctm_pkg::FS_FLAGS,
                             60'((1 << ctm_pkg::FLAG_PRESENT) | (1 << ctm_pkg::FLAG_BOOT))));
        // job 31: only the top bit of each mask
        send_word(write_word(5'd31, ctm_pkg::FS_SEC, 60'd1 << 59));
        send_word(write_word(5'd31, ctm_pkg::FS_MIN, 60'd1 << 59));
        send_word(write_word(5'd31, ctm_pkg::FS_HOUR, 60'd1 << 23));
        send_word(write_word(5'd31, ctm_pkg::FS_DAY, 60'd1 << 30));
        send_word(write_word(5'd31, ctm_pkg::FS_MONTH, 60'd1 << 11));
        send_word(write_word(5'd31, ctm_pkg::FS_WEEKDAY, 60'd1 << 7));
        send_word(write_word(5'd31, ctm_pkg::FS_FLAGS, 60'(1 << ctm_pkg::FLAG_PRESENT)));
        send_word(tick_word(59, 59, 23, 31, 12, 7));
        // times out of range, day zero and month 15
        send_word(tick_word(63, 63, 31, 0, 15, 0));
        send_word(tick_word(0, 0, 0, 1, 1, 0));
        w = noise_word();
        w.opcode = OP_UNUSED;
        send_word(w);
        send_word(write_word(5'd0, FS_UNUSED, '1));
        send_word(write_word(5'd31, ctm_pkg::FS_FLAGS,
                             60'((1 << ctm_pkg::FLAG_PRESENT) |
                                 (1 << ctm_pkg::FLAG_DAY_ANY))));
        // boot flag on an absent job
        send_word(write_word(5'd5, ctm_pkg::FS_FLAGS, 60'(1 << ctm_pkg::FLAG_BOOT)));
        send_word(tick_word(59, 59, 23, 31, 12, 0));
        w = noise_word();
        w.opcode = ctm_pkg::OP_CLEAR;
        send_word(w);
        send_word(tick_word(59, 59, 23, 31, 12, 7));
        drain();

        start = words_sent;
        while (words_sent < start + RANDOM_WORDS)
        begin
            if (!drained && words_sent >= start + RANDOM_WORDS / 2)
            begin
                drain();
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 35)
                program_job(5'($urandom_range(31)));
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    w = noise_word();
                    w.opcode = ctm_pkg::OP_TICK;
                    if ($urandom_range(99) < 85)
                    begin
                        w.second       = 6'($urandom_range(59));
                        w.minute       = 6'($urandom_range(59));
                        w.hour         = 5'($urandom_range(23));
                        w.day_of_month = 5'($urandom_range(1, 31));
                        w.month_number = 4'($urandom_range(1, 12));
                        w.day_of_week  = 3'($urandom_range(7));
                    end
                    send_word(w);
                end
            end
            else
            begin
                w = noise_word();
                case ($urandom_range(5))
                    0:       w.opcode = ctm_pkg::OP_CLEAR;
                    1:       w.opcode = OP_UNUSED;
                    default: w.opcode = ctm_pkg::OP_WRITE;
                endcase
                send_word(w);
            end
        end

        drain();
        repeat (2 * JOBS + 8) @(negedge clk);
        if (due_jobs.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/ctm_pkg.sv
design/ctm_job_cell.sv
design/cron_time_match_table.sv
design/ctm_checker.sv
tb/sv/tb.sv
